// ----- hw/rtl/sdtt_pkg.sv -----
package sdtt_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned PhaseW  = 16;
  localparam int unsigned PowerW  = 12;
  localparam int unsigned LevelW  = 9;
  localparam int unsigned WidthW  = 8;
  localparam int unsigned AmpW    = 8;
  localparam int unsigned SampleW = 10;
  localparam int unsigned CfgIdxW = 8;

  // Operation codes carried by the opcode field.
  localparam logic OpTick     = 1'b0;
  localparam logic OpSetSpeed = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegVoiceOneAmp = 8'd0;
  localparam logic [CfgIdxW-1:0] RegVoiceTwoAmp = 8'd1;

  // Power curve and voice constants.
  localparam logic [PowerW:0]   PowerBias     = 13'h0200;
  localparam logic [PowerW:0]   PowerMax      = 13'h0FFF;
  localparam logic [SpeedW-1:0] FastThreshold = 16'h0A00;
  localparam logic [LevelW-1:0] IdleLevel     = 9'h060;
  localparam int unsigned       SampleRate    = 32000;
  localparam int unsigned       ToneOneHz     = 200;
  localparam int unsigned       ToneTwoHz     = 400;
  localparam logic [PhaseW-1:0] SlowStepOne   = PhaseW'((ToneOneHz * 65536) / SampleRate);
  localparam logic [PhaseW-1:0] SlowStepTwo   = PhaseW'((ToneTwoHz * 65536) / SampleRate);
  localparam logic [PhaseW-1:0] ResetStepOne  = 16'h0500;
  localparam logic [PhaseW-1:0] ResetStepTwo  = 16'h0180;
  localparam logic [AmpW-1:0]   ResetAmp      = 8'hFF;

  // Voice settings derived from the last speed.
  typedef struct packed {
    logic              running;
    logic [LevelW-1:0] dc_level;
    logic [WidthW-1:0] pulse_width;
    logic [PhaseW-1:0] step_one;
    logic [PhaseW-1:0] step_two;
  } voice_set_t;

endpackage

// ----- hw/rtl/sdtt_speed_ctrl.sv -----
module sdtt_speed_ctrl
  import sdtt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [SpeedW-1:0] speed_i,
  output voice_set_t        set_o
);

  voice_set_t set_q, set_d;
  logic [PowerW:0]   power_raw;
  logic [PowerW-1:0] power;

  // Power from speed, clamped to the top of the range.
  assign power_raw = {1'b0, speed_i[SpeedW-1:4]} + PowerBias;
  assign power     = (power_raw > PowerMax) ? PowerMax[PowerW-1:0]
                                            : power_raw[PowerW-1:0];

  // Next settings for a set-speed beat.
  always_comb begin
    set_d = set_q;
    if (load_i) begin
      if (speed_i == '0) begin
        set_d.running  = 1'b0;
        set_d.dc_level = IdleLevel;
      end else begin
        set_d.running     = 1'b1;
        set_d.dc_level    = power[PowerW-1:3];
        set_d.pulse_width = power[PowerW-1:4];
        if (speed_i >= FastThreshold) begin
          set_d.step_one = {6'd0, speed_i[SpeedW-1:6]};
          set_d.step_two = {6'd0, speed_i[SpeedW-1:6]} + {4'd0, speed_i[SpeedW-1:4]};
        end else begin
          set_d.step_one = SlowStepOne;
          set_d.step_two = SlowStepTwo;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q.running     <= 1'b0;
      set_q.dc_level    <= '0;
      set_q.pulse_width <= '0;
      set_q.step_one    <= ResetStepOne;
      set_q.step_two    <= ResetStepTwo;
    end else begin
      set_q <= set_d;
    end
  end

  assign set_o = set_q;

endmodule

// ----- hw/rtl/sdtt_voice.sv -----
module sdtt_voice
  import sdtt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  voice_set_t         set_i,
  input  logic [AmpW-1:0]    amp_one_i,
  input  logic [AmpW-1:0]    amp_two_i,
  output logic [SampleW-1:0] sample_o
);

  logic [PhaseW-1:0] phase_one_q, phase_one_d;
  logic [PhaseW-1:0] phase_two_q, phase_two_d;
  logic [PhaseW-1:0] phase_one_nx, phase_two_nx;
  logic              pulse_one, pulse_two;

  // Both phases advance together while running; they wrap naturally.
  assign phase_one_nx = set_i.running ? phase_one_q + set_i.step_one : phase_one_q;
  assign phase_two_nx = set_i.running ? phase_two_q + set_i.step_two : phase_two_q;
  assign phase_one_d  = tick_i ? phase_one_nx : phase_one_q;
  assign phase_two_d  = tick_i ? phase_two_nx : phase_two_q;

  // A pulse is high while the phase's high byte is under the width.
  assign pulse_one = set_i.running && (phase_one_nx[PhaseW-1:8] < set_i.pulse_width);
  assign pulse_two = set_i.running && (phase_two_nx[PhaseW-1:8] < set_i.pulse_width);

  assign sample_o = {1'b0, set_i.dc_level}
                  + (pulse_one ? {2'b00, amp_one_i} : '0)
                  + (pulse_two ? {2'b00, amp_two_i} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_one_q <= '0;
      phase_two_q <= '0;
    end else begin
      phase_one_q <= phase_one_d;
      phase_two_q <= phase_two_d;
    end
  end

endmodule

// ----- hw/rtl/speed_driven_two_tone_pulse_synth_top.sv -----
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | opcode_i, speed_i
// out     | output    | out_valid_o / out_ready_i | sample_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled: a beat is registered in the input register, then processed.
// A tick's sample passes the input register and then the output register; a set-speed beat gives none.
// The phase add and compare form a single combinational stage ahead of the output register.
// Reset clears the voices to stopped with level zero and both amplitudes to 255.
// A stalled output holds its sample; set-speed beats still drain past it.
module speed_driven_two_tone_pulse_synth_top
  import sdtt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [SpeedW-1:0]  speed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] sample_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AmpW-1:0]    cfg_data_i
);

  logic               s1_valid_q, s1_valid_d;
  logic               s1_op_q;
  logic [SpeedW-1:0]  s1_speed_q;
  logic               s1_fire, tick_fire, load_fire;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] sample_q;
  logic [SampleW-1:0] sample_calc;
  logic [AmpW-1:0]    amp_one_q, amp_two_q;
  voice_set_t         settings;

  // A set-speed beat never waits; a tick waits for a free output register.
  assign s1_fire    = s1_valid_q && (s1_op_q == OpSetSpeed || !out_valid_q || out_ready_i);
  assign tick_fire  = s1_fire && (s1_op_q == OpTick);
  assign load_fire  = s1_fire && (s1_op_q == OpSetSpeed);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign s1_valid_d = (in_valid_i && in_ready_o) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= opcode_i;
      s1_speed_q <= speed_i;
    end
  end

  sdtt_speed_ctrl u_speed_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load_fire),
    .speed_i (s1_speed_q),
    .set_o   (settings)
  );

  sdtt_voice u_voice (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick_fire),
    .set_i     (settings),
    .amp_one_i (amp_one_q),
    .amp_two_i (amp_two_q),
    .sample_o  (sample_calc)
  );

  // Output register.
  assign out_valid_d = tick_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      sample_q <= sample_calc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_one_q <= ResetAmp;
      amp_two_q <= ResetAmp;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegVoiceOneAmp: amp_one_q <= cfg_data_i;
        RegVoiceTwoAmp: amp_two_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  // A tick blocked by a held result stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_op_q == OpTick && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("blocked tick left the input register");

  // A set-speed beat produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire && !(out_valid_q && !out_ready_i) |=> !out_valid_o)
    else $error("set-speed beat produced a result");

  // While stopped, a tick reports the DC level alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire && !settings.running |=> sample_o == {1'b0, $past(settings.dc_level)})
    else $error("stopped tick carried pulse amplitude");
`endif

endmodule

// ----- tb/tb_speed_driven_two_tone_pulse_synth_top.sv -----
module tb_speed_driven_two_tone_pulse_synth_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdtt_pkg::*;

  localparam int unsigned NumPhases    = 7;
  localparam int unsigned RandomItems  = 1725;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned BurstItems   = 80;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned NumDirected  = 23;

  // First register index that the block does not implement.
  localparam logic [CfgIdxW-1:0] FirstUnusedReg = RegVoiceTwoAmp + 1'b1;

  // Predicts the sample of every tick and holds the samples still owed.
  class pulse_sample_scoreboard;
    logic [AmpW-1:0]    amp_one;
    logic [AmpW-1:0]    amp_two;
    logic               running;
    logic [LevelW-1:0]  level;
    logic [WidthW-1:0]  width;
    logic [PhaseW-1:0]  step_one;
    logic [PhaseW-1:0]  step_two;
    logic [PhaseW-1:0]  phase_one;
    logic [PhaseW-1:0]  phase_two;
    logic [SampleW-1:0] owed_samples[$];
    int unsigned        errors;
    int unsigned        samples_checked;
    int unsigned        speed_changes;
    int unsigned        stops;
    int unsigned        reg_writes;

    function new();
      amp_one         = ResetAmp;
      amp_two         = ResetAmp;
      running         = 1'b0;
      level           = '0;
      width           = '0;
      step_one        = ResetStepOne;
      step_two        = ResetStepTwo;
      phase_one       = '0;
      phase_two       = '0;
      errors          = 0;
      samples_checked = 0;
      speed_changes   = 0;
      stops           = 0;
      reg_writes      = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [AmpW-1:0] data);
      reg_writes++;
      if (idx == RegVoiceOneAmp) begin
        amp_one = data;
      end else if (idx == RegVoiceTwoAmp) begin
        amp_two = data;
      end
    endfunction

    // A nonzero speed sets the level, the shared pulse width and both steps; zero stops at the idle level.
    function void take_speed(logic [SpeedW-1:0] spd);
      logic [PowerW:0] power;
      speed_changes++;
      running = (spd != '0);
      if (!running) begin
        stops++;
        level = IdleLevel;
        return;
      end
      power = (PowerW + 1)'(spd >> 4) + PowerBias;
      if (power > PowerMax) begin
        power = PowerMax;
      end
      level = LevelW'(power >> 3);
      width = WidthW'(power >> 4);
      if (spd >= FastThreshold) begin
        step_one = spd >> 6;
        step_two = (spd >> 6) + (spd >> 4);
      end else begin
        step_one = SlowStepOne;
        step_two = SlowStepTwo;
      end
    endfunction

    // A tick advances both phases while running, then tests each pulse.
    function logic [SampleW-1:0] next_sample();
      logic [SampleW-1:0] acc;
      acc = SampleW'(level);
      if (running) begin
        phase_one = phase_one + step_one;
        phase_two = phase_two + step_two;
        if (phase_one[PhaseW-1:8] < width) begin
          acc = acc + SampleW'(amp_one);
        end
        if (phase_two[PhaseW-1:8] < width) begin
          acc = acc + SampleW'(amp_two);
        end
      end
      return acc;
    endfunction

    function void note_item(logic op, logic [SpeedW-1:0] spd);
      if (op == OpSetSpeed) begin
        take_speed(spd);
      end else begin
        owed_samples.push_back(next_sample());
      end
    endfunction

    task check_sample(logic [SampleW-1:0] got);
      logic [SampleW-1:0] want;
      if (owed_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with no tick waiting", got));
        return;
      end
      want = owed_samples.pop_front();
      samples_checked++;
      if (got !== want) begin
        report_mismatch($sformatf("sample: got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               opcode_i;
  logic [SpeedW-1:0]  speed_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SampleW-1:0] sample_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [AmpW-1:0]    cfg_data_i;

  pulse_sample_scoreboard sb;
  bit                     hold_req = 1'b0;
  int unsigned            holds_done = 0;
  int unsigned            quiet_cycles = 0;

  speed_driven_two_tone_pulse_synth_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .speed_i     (speed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 2);
    if (roll < 92) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // Speeds lean toward stops, the slow range, the threshold and the top end, with the full range on top.
  function automatic logic [SpeedW-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SpeedW'($urandom_range(1, FastThreshold - 1));
      2:       return SpeedW'($urandom_range(FastThreshold, FastThreshold + 64));
      3:       return SpeedW'($urandom_range(16'hDFC0, 16'hFFFF));
      default: return SpeedW'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Watch all three channels; every accepted beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_item(opcode_i, speed_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_sample(sample_o);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(cfg_index_i, cfg_data_i);
      end
    end
  end

  // End the run if no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no beat accepted for %0d cycles", QuietLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls, stretches at full rate, and one long hold-off on request.
  initial begin : sample_sink
    int unsigned stall_left;
    int unsigned mode_left;
    bit          full_rate;
    out_ready_i = 1'b0;
    stall_left  = 0;
    mode_left   = 0;
    full_rate   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          full_rate = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 200);
        end
        mode_left--;
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end else begin
          out_ready_i <= 1'b1;
          if (!full_rate && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
          end
        end
      end
    end
  end

  // Offer one item and hold it until accepted; valid stays high for a following beat.
  task automatic send_item(input logic op, input logic [SpeedW-1:0] spd);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    speed_i    <= spd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid for a while after a beat, unless the caller wants back-to-back beats.
  task automatic pause_after(input bit back_to_back);
    int unsigned gap;
    gap = 0;
    if (!back_to_back && $urandom_range(0, 9) < 4) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Offer one register write and hold it until accepted; the caller drops valid afterwards.
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [AmpW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Let every owed sample come out, then give the pipeline time to empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed_samples.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Ticks before any speed, stops, both step ranges, the threshold and power clamping.
  task automatic run_directed();
    logic [SpeedW:0] plan [NumDirected];
    plan = '{
      {OpTick, 16'hFFFF},
      {OpSetSpeed, 16'h0000}, {OpTick, 16'h0000},
      {OpSetSpeed, 16'h0001}, {OpTick, 16'hFFFF}, {OpTick, 16'h0000},
      {OpSetSpeed, 16'h09FF}, {OpTick, 16'hAAAA},
      {OpSetSpeed, 16'h0A00}, {OpTick, 16'h5555},
      {OpSetSpeed, 16'hDFF0}, {OpTick, 16'h0000},
      {OpSetSpeed, 16'hFFFF}, {OpTick, 16'hFFFF}, {OpTick, 16'h0000}, {OpTick, 16'h1234},
      {OpSetSpeed, 16'h0000}, {OpTick, 16'hFFFF},
      {OpSetSpeed, 16'h8000}, {OpTick, 16'h0000}, {OpTick, 16'hFFFF},
      {OpSetSpeed, 16'h000F}, {OpTick, 16'h0000}
    };
    foreach (plan[i]) begin
      send_item(plan[i][SpeedW], plan[i][SpeedW-1:0]);
      pause_after(1'b0);
    end
  endtask

  // Random speeds each followed by a run of ticks; optionally one burst against a held receiver.
  task automatic run_random(input int unsigned count, input bit with_hold);
    int unsigned burst_left;
    int unsigned rate_left;
    bit          full_rate;
    logic        op;
    burst_left = 0;
    rate_left  = 0;
    full_rate  = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) begin
        hold_req   = 1'b1;
        burst_left = BurstItems;
      end
      if (rate_left == 0) begin
        full_rate = ($urandom_range(0, 3) == 0);
        rate_left = $urandom_range(20, 80);
      end
      rate_left--;
      op = ($urandom_range(0, 99) < 18) ? OpSetSpeed : OpTick;
      if (op == OpSetSpeed) begin
        send_item(OpSetSpeed, pick_speed());
      end else begin
        send_item(OpTick, SpeedW'($urandom_range(0, 16'hFFFF)));
      end
      pause_after(full_rate || burst_left > 0);
      if (burst_left > 0) burst_left--;
    end
  endtask

  // Amplitude settings per phase: the extremes first, then random values.
  initial begin : stimulus
    logic [AmpW-1:0] amp_one_plan [4];
    logic [AmpW-1:0] amp_two_plan [4];
    logic [AmpW-1:0] amp_one;
    logic [AmpW-1:0] amp_two;
    amp_one_plan = '{8'hFF, 8'h00, 8'hFF, 8'h00};
    amp_two_plan = '{8'hFF, 8'h00, 8'h00, 8'hFF};
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OpTick;
    speed_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegVoiceOneAmp;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items run with the amplitudes as they come out of reset.
    run_directed();
    settle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      amp_one = (p < 4) ? amp_one_plan[p] : AmpW'($urandom_range(0, 255));
      amp_two = (p < 4) ? amp_two_plan[p] : AmpW'($urandom_range(0, 255));
      write_cfg(RegVoiceOneAmp, amp_one);
      write_cfg(RegVoiceTwoAmp, amp_two);
      // Writes to unimplemented indexes must leave both amplitudes alone.
      if (p == 1) begin
        write_cfg(FirstUnusedReg, AmpW'($urandom_range(0, 255)));
      end else if (p == NumPhases - 1) begin
        write_cfg({CfgIdxW{1'b1}}, AmpW'($urandom_range(0, 255)));
      end
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      run_random(RandomItems / NumPhases, p == 2);
      settle();
    end

    $display("Checked %0d samples across %0d speed changes (%0d stops) and %0d register writes.",
             sb.samples_checked, sb.speed_changes, sb.stops, sb.reg_writes);
    $display("Receiver held off %0d time(s) for %0d cycles; both sides idled at random.",
             holds_done, HoldCycles);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
